### design/pair_relative_momentum_defines.svh
// Assertion macros shared by the pair relative momentum design.
`ifndef PAIR_RELATIVE_MOMENTUM_DEFINES_SVH
`define PAIR_RELATIVE_MOMENTUM_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PRM_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PRM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/prm_pkg.sv
// Shared constants, types and helper functions for the pair relative momentum pipeline.
package prm_pkg;

    // Square root unit: radicand and root widths, one root bit per stage.
    localparam int ISQ_N = 29;
    localparam int RAD_W = 2 * ISQ_N;

    // Divider: numerator, denominator and quotient widths, one quotient bit per stage.
    localparam int DIV_N = 19;
    localparam int NUM_W = 59;
    localparam int DEN_W = 40;

    // Field widths.
    localparam int MOM_W  = 18;
    localparam int MASS_W = 14;
    localparam int OUT_W  = 18;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Total register stages from input to output register.
    localparam int PIPE_N = 3 + ISQ_N + 4 + ISQ_N + 2 + DIV_N + 1;

    typedef logic [RAD_W-1:0] rad_t;
    typedef logic [ISQ_N-1:0] root_t;
    typedef logic [OUT_W-1:0] out_t;

    // Data that travels beside the energy and kT square roots.
    typedef struct packed {
        rad_t               pp;
        logic [MASS_W:0]    msum;
        logic [MASS_W-1:0]  mdif;
    } band_a_t;

    // Data that travels beside the divider.
    typedef struct packed {
        logic mzero;
        out_t kt;
        out_t mt;
    } band_c_t;

    // Square of an 18-bit signed value.
    function automatic logic [34:0] sq18(input logic signed [17:0] v);
        logic signed [35:0] p;
        p = 36'(v) * 36'(v);
        return p[34:0];
    endfunction

    // Square of a 19-bit signed value.
    function automatic logic [36:0] sq19(input logic signed [18:0] v);
        logic signed [37:0] p;
        p = 38'(v) * 38'(v);
        return p[36:0];
    endfunction

    // Round a Q.8 root to an integer, half up, and saturate.
    function automatic out_t round_sat(input root_t v);
        logic [ISQ_N:0] r;
        r = ({1'b0, v} + (ISQ_N+1)'(128)) >> 8;
        if (r > (ISQ_N+1)'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

### design/prm_isqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
module prm_isqrt
    import prm_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  rad_t  rad,
    output root_t root
);

    rad_t  rem_reg [ISQ_N-1];
    root_t rt_reg  [ISQ_N];

    genvar g;
    generate
        for (g = 0; g < ISQ_N; g++) begin : g_stage
            localparam int BIT = ISQ_N - 1 - g;
            rad_t           rem_in;
            root_t          rt_in;
            logic [RAD_W+1:0] trial;
            logic           take;

            // Stage input: the radicand itself at the head, the previous stage otherwise.
            if (g == 0) begin : g_head
                assign rem_in = rad;
                assign rt_in  = '0;
            end else begin : g_body
                assign rem_in = rem_reg[g-1];
                assign rt_in  = rt_reg[g-1];
            end

            // Setting this bit adds 2*r*2^BIT + 2^(2*BIT) to the square.
            assign trial = ((RAD_W+2)'(rt_in) << (BIT + 1))
                         + ((RAD_W+2)'(1) << (2 * BIT));
            assign take  = {2'b00, rem_in} >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rt_reg[g] <= take ? (rt_in | (ISQ_N'(1) << BIT)) : rt_in;
                end
            end

            // The remainder is carried on to every stage but the last.
            if (g < ISQ_N - 1) begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[g] <= take ? (rem_in - trial[RAD_W-1:0]) : rem_in;
                    end
                end
            end
        end
    endgenerate

    assign root = rt_reg[ISQ_N-1];

endmodule

### design/prm_div.sv
// Pipelined restoring divider, one quotient bit resolved per register stage.
module prm_div
    import prm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [DIV_N-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [DIV_N-1];
    logic [DEN_W-1:0] den_reg [DIV_N-1];
    logic [DIV_N-1:0] q_reg   [DIV_N];

    genvar g;
    generate
        for (g = 0; g < DIV_N; g++) begin : g_stage
            localparam int BIT = DIV_N - 1 - g;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [DIV_N-1:0] q_in;
            logic [NUM_W:0]   trial;
            logic             take;

            // Stage input: the operands at the head, the previous stage otherwise.
            if (g == 0) begin : g_head
                assign rem_in = num;
                assign den_in = den;
                assign q_in   = '0;
            end else begin : g_body
                assign rem_in = rem_reg[g-1];
                assign den_in = den_reg[g-1];
                assign q_in   = q_reg[g-1];
            end

            // Subtract the shifted divisor when it fits.
            assign trial = (NUM_W+1)'(den_in) << BIT;
            assign take  = {1'b0, rem_in} >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[g] <= take ? (q_in | (DIV_N'(1) << BIT)) : q_in;
                end
            end

            if (g < DIV_N - 1) begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[g] <= take ? (rem_in - trial[NUM_W-1:0]) : rem_in;
                        den_reg[g] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_N-1];

endmodule

### design/pair_relative_momentum.sv
// Top level of the pair rest-frame relative momentum pipeline (k*, kT, mT).
//
// Usage:
// The input channel (pair_valid, pair_stall) carries one particle pair per item:
// three signed momentum components and a mass for each particle, in MeV.
// The result channel (result_valid, result_stall) carries kstar, pair_kt and
// pair_mt for each pair, in the order the pairs came in, one result per pair.
// The path from input to the output register has 87 register stages, the first
// loaded at the accepting edge.
// One pair can enter every cycle while pair_stall is low; the depth comes from
// two rows of 29-stage square root units and a 19-stage divider.
// The whole pipeline moves as one: when a finished result waits and
// result_stall is high, every stage holds and pair_stall is raised, so no item
// is lost or repeated. Bubbles in the pipeline do not hold it back.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep
// whatever they held and carry no meaning until a valid item reaches them.
`include "pair_relative_momentum_defines.svh"

module pair_relative_momentum
    import prm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pair_valid,
    output logic                     pair_stall,
    input  logic signed [MOM_W-1:0]  first_px,
    input  logic signed [MOM_W-1:0]  first_py,
    input  logic signed [MOM_W-1:0]  first_pz,
    input  logic        [MASS_W-1:0] first_mass,
    input  logic signed [MOM_W-1:0]  second_px,
    input  logic signed [MOM_W-1:0]  second_py,
    input  logic signed [MOM_W-1:0]  second_pz,
    input  logic        [MASS_W-1:0] second_mass,
    output logic                     result_valid,
    input  logic                     result_stall,
    output out_t                     kstar,
    output out_t                     pair_kt,
    output out_t                     pair_mt
);

    logic              adv;
    logic [PIPE_N-1:0] vld_reg;

    // The pipeline advances unless a finished result is held by the receiver.
    assign adv          = !(vld_reg[PIPE_N-1] && result_stall);
    assign pair_stall   = !adv;
    assign result_valid = vld_reg[PIPE_N-1];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_N-2:0], pair_valid};
        end
    end

    // Stage 1: squares of the components and masses, and the summed momentum.
    logic [34:0]             ax2_reg, ay2_reg, az2_reg, bx2_reg, by2_reg, bz2_reg;
    logic [2*MASS_W-1:0]     m1sq_reg, m2sq_reg;
    logic signed [MOM_W:0]   sx_reg, sy_reg, sz_reg;
    logic [MASS_W-1:0]       m1_reg, m2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg  <= sq18(first_px);
            ay2_reg  <= sq18(first_py);
            az2_reg  <= sq18(first_pz);
            bx2_reg  <= sq18(second_px);
            by2_reg  <= sq18(second_py);
            bz2_reg  <= sq18(second_pz);
            m1sq_reg <= first_mass * first_mass;
            m2sq_reg <= second_mass * second_mass;
            sx_reg   <= (MOM_W+1)'(first_px) + (MOM_W+1)'(second_px);
            sy_reg   <= (MOM_W+1)'(first_py) + (MOM_W+1)'(second_py);
            sz_reg   <= (MOM_W+1)'(first_pz) + (MOM_W+1)'(second_pz);
            m1_reg   <= first_mass;
            m2_reg   <= second_mass;
        end
    end

    // Stage 2: energy radicands in Q.20, pair momentum squares, mass sum and difference.
    logic [35:0]       e1sum_next, e2sum_next;
    rad_t              rad1_reg, rad2_reg;
    logic [36:0]       sx2_reg, sy2_reg, sz2_reg;
    logic [MASS_W:0]   msum_reg;
    logic [MASS_W-1:0] mdif_reg;

    assign e1sum_next = 36'(ax2_reg) + 36'(ay2_reg) + 36'(az2_reg) + 36'(m1sq_reg);
    assign e2sum_next = 36'(bx2_reg) + 36'(by2_reg) + 36'(bz2_reg) + 36'(m2sq_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad1_reg <= RAD_W'({e1sum_next, 20'd0});
            rad2_reg <= RAD_W'({e2sum_next, 20'd0});
            sx2_reg  <= sq19(sx_reg);
            sy2_reg  <= sq19(sy_reg);
            sz2_reg  <= sq19(sz_reg);
            msum_reg <= (MASS_W+1)'(m1_reg) + (MASS_W+1)'(m2_reg);
            mdif_reg <= (m1_reg > m2_reg) ? (m1_reg - m2_reg) : (m2_reg - m1_reg);
        end
    end

    // Stage 3: transverse radicand for kT in Q.14 and total momentum square in Q.20.
    logic [37:0] pt2_next, p2_next;
    rad_t        e1rad_reg, e2rad_reg, ktrad_reg;
    band_a_t     band_a_reg;

    assign pt2_next = 38'(sx2_reg) + 38'(sy2_reg);
    assign p2_next  = pt2_next + 38'(sz2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1rad_reg       <= rad1_reg;
            e2rad_reg       <= rad2_reg;
            ktrad_reg       <= RAD_W'({pt2_next, 14'd0});
            band_a_reg.pp   <= RAD_W'({p2_next, 20'd0});
            band_a_reg.msum <= msum_reg;
            band_a_reg.mdif <= mdif_reg;
        end
    end

    // First row of square roots: both energies and kT, all in Q.10 or Q.8.
    root_t e1_root, e2_root, kt_root;

    prm_isqrt u_isqrt_e1 (.clk(clk), .en(adv), .rad(e1rad_reg), .root(e1_root));
    prm_isqrt u_isqrt_e2 (.clk(clk), .en(adv), .rad(e2rad_reg), .root(e2_root));
    prm_isqrt u_isqrt_kt (.clk(clk), .en(adv), .rad(ktrad_reg), .root(kt_root));

    // Side data delayed to meet the roots.
    band_a_t band_a_dly_reg [ISQ_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            band_a_dly_reg[0] <= band_a_reg;
            for (int k = 1; k < ISQ_N; k++)
            begin
                band_a_dly_reg[k] <= band_a_dly_reg[k-1];
            end
        end
    end

    // T1: energy sum, kT square, mass squares, rounded kT output.
    logic [ISQ_N:0]      es_reg;
    logic [2*ISQ_N-1:0]  kt2_next;
    rad_t                kt2_reg, pp1_reg;
    logic [2*MASS_W+1:0] msum2_reg;
    logic [2*MASS_W-1:0] mdif2_reg;
    out_t                kt1_reg;
    band_a_t             band_q;

    assign band_q   = band_a_dly_reg[ISQ_N-1];
    assign kt2_next = kt_root * kt_root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            es_reg    <= (ISQ_N+1)'(e1_root) + (ISQ_N+1)'(e2_root);
            kt2_reg   <= kt2_next;
            msum2_reg <= band_q.msum * band_q.msum;
            mdif2_reg <= band_q.mdif * band_q.mdif;
            pp1_reg   <= band_q.pp;
            kt1_reg   <= round_sat(kt_root);
        end
    end

    // T2: energy sum squared and the mT radicand (kT^2 + mean mass^2, Q.16).
    logic [2*ISQ_N+1:0]  es2_next;
    rad_t                es2_reg, pp2_reg, mtrad2_reg;
    logic [2*MASS_W+1:0] msum2b_reg;
    logic [2*MASS_W-1:0] mdif2b_reg;
    out_t                kt2o_reg;

    assign es2_next = es_reg * es_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            es2_reg    <= es2_next[RAD_W-1:0];
            mtrad2_reg <= kt2_reg + RAD_W'({msum2_reg, 14'd0});
            pp2_reg    <= pp1_reg;
            msum2b_reg <= msum2_reg;
            mdif2b_reg <= mdif2_reg;
            kt2o_reg   <= kt1_reg;
        end
    end

    // T3: invariant mass squared, clamped at zero.
    rad_t                s3_reg, mtrad3_reg;
    logic [2*MASS_W+1:0] msum2c_reg;
    logic [2*MASS_W-1:0] mdif2c_reg;
    out_t                kt3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg     <= (es2_reg > pp2_reg) ? (es2_reg - pp2_reg) : '0;
            mtrad3_reg <= mtrad2_reg;
            msum2c_reg <= msum2b_reg;
            mdif2c_reg <= mdif2b_reg;
            kt3_reg    <= kt2o_reg;
        end
    end

    // T4: threshold terms s - (m1+m2)^2 and s - (m1-m2)^2, clamped at zero.
    rad_t msq_next, mdq_next;
    rad_t s4_reg, a4_reg, b4_reg, mtrad4_reg;
    out_t kt4_reg;

    assign msq_next = RAD_W'({msum2c_reg, 20'd0});
    assign mdq_next = RAD_W'({mdif2c_reg, 20'd0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg     <= s3_reg;
            a4_reg     <= (s3_reg > msq_next) ? (s3_reg - msq_next) : '0;
            b4_reg     <= (s3_reg > mdq_next) ? (s3_reg - mdq_next) : '0;
            mtrad4_reg <= mtrad3_reg;
            kt4_reg    <= kt3_reg;
        end
    end

    // Second row of square roots: pair mass, both threshold roots and mT.
    root_t m_root, sa_root, sb_root, mt_root;

    prm_isqrt u_isqrt_m  (.clk(clk), .en(adv), .rad(s4_reg),     .root(m_root));
    prm_isqrt u_isqrt_sa (.clk(clk), .en(adv), .rad(a4_reg),     .root(sa_root));
    prm_isqrt u_isqrt_sb (.clk(clk), .en(adv), .rad(b4_reg),     .root(sb_root));
    prm_isqrt u_isqrt_mt (.clk(clk), .en(adv), .rad(mtrad4_reg), .root(mt_root));

    out_t kt_dly_reg [ISQ_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kt_dly_reg[0] <= kt4_reg;
            for (int k = 1; k < ISQ_N; k++)
            begin
                kt_dly_reg[k] <= kt_dly_reg[k-1];
            end
        end
    end

    // U1: product of the threshold roots, rounded mT output.
    logic [2*ISQ_N-1:0] prod_next;
    logic [2*ISQ_N-1:0] prod_reg;
    root_t              mroot_reg;
    out_t               ktu1_reg, mtu1_reg;

    assign prod_next = sa_root * sb_root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            mroot_reg <= m_root;
            ktu1_reg  <= kt_dly_reg[ISQ_N-1];
            mtu1_reg  <= round_sat(mt_root);
        end
    end

    // U2: rounding numerator and divisor 2*M for k*.
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    band_c_t          band_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg          <= NUM_W'(prod_reg) + NUM_W'({mroot_reg, 10'd0});
            den_reg          <= DEN_W'({mroot_reg, 11'd0});
            band_c_reg.mzero <= (mroot_reg == '0);
            band_c_reg.kt    <= ktu1_reg;
            band_c_reg.mt    <= mtu1_reg;
        end
    end

    // Divider for k*, with its side data delayed alongside.
    logic [DIV_N-1:0] quo;
    band_c_t          band_c_dly_reg [DIV_N];
    band_c_t          dv_band;

    prm_div u_div (.clk(clk), .en(adv), .num(num_reg), .den(den_reg), .quo(quo));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            band_c_dly_reg[0] <= band_c_reg;
            for (int k = 1; k < DIV_N; k++)
            begin
                band_c_dly_reg[k] <= band_c_dly_reg[k-1];
            end
        end
    end

    assign dv_band = band_c_dly_reg[DIV_N-1];

    // Output register: zero pair mass gives k* of zero; the quotient saturates.
    out_t kstar_next;
    out_t kstar_reg, pair_kt_reg, pair_mt_reg;

    always_comb
    begin
        if (dv_band.mzero)
        begin
            kstar_next = '0;
        end
        else if (quo[DIV_N-1])
        begin
            kstar_next = OUT_MAX;
        end
        else
        begin
            kstar_next = quo[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kstar_reg   <= kstar_next;
            pair_kt_reg <= dv_band.kt;
            pair_mt_reg <= dv_band.mt;
        end
    end

    assign kstar   = kstar_reg;
    assign pair_kt = pair_kt_reg;
    assign pair_mt = pair_mt_reg;

    // Checks on the pipeline control and on the results.
    `PRM_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(vld_reg), "pipeline moved while stalled")
    `PRM_ASSERT_NEXT(a_zero_mass_kstar, vld_reg[PIPE_N-2] && adv && dv_band.mzero, kstar == '0, "k* not zero for zero pair mass")
    `PRM_ASSERT_IMPL(a_mt_not_below_kt, result_valid, pair_mt >= pair_kt, "mT below kT")

endmodule
